// ----- rtl/madr_pkg.sv -----
package madr_pkg;

  localparam int SMP_W      = 24;
  localparam int SLACK_W    = 13;
  localparam int DELAY_W    = 12;
  localparam int KIND_W     = 2;
  localparam int CHAN_W     = 1;

  localparam int DEPTH_DEFAULT    = 4096;
  localparam int CHANNELS_DEFAULT = 2;

  localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(128);

  localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACC   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic item_load;
    logic mem_wr;
    logic mem_rd;
    logic acc_wb;
    logic clr_start;
    logic clr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              clr_last;
    logic              out_busy;
  } sts_t;

endpackage

// ----- rtl/madr_ctrl.sv -----
module madr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  madr_pkg::sts_t  sts_i,
  output madr_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_RESP = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.kind)
          madr_pkg::KIND_WRITE: begin
            cmd_o.mem_wr = 1'b1;
            state_d      = ST_IDLE;
          end
          madr_pkg::KIND_READ: begin
            cmd_o.mem_rd = 1'b1;
            state_d      = ST_RESP;
          end
          madr_pkg::KIND_ACC: begin
            cmd_o.mem_rd = 1'b1;
            state_d      = ST_ACC;
          end
          default: begin
            cmd_o.clr_start = 1'b1;
            state_d         = ST_CLR;
          end
        endcase
      end
      ST_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ACC: begin
        cmd_o.acc_wb = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.item_load |=> (state_q == ST_EXEC))
    else $error("item load did not lead to execute");

  a_acc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_wb |-> $past(cmd_o.mem_rd))
    else $error("accumulate write-back without preceding read");

  a_resp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && sts_i.out_busy) |=> (state_q == ST_RESP))
    else $error("read beat dropped while output stalled");

endmodule

// ----- rtl/madr_dp.sv -----
module madr_dp #(
  parameter int DEPTH    = madr_pkg::DEPTH_DEFAULT,
  parameter int CHANNELS = madr_pkg::CHANNELS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  madr_pkg::cmd_t                    cmd_i,
  output madr_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic [madr_pkg::SLACK_W-1:0]      cfg_wdata_i,
  input  logic [madr_pkg::KIND_W-1:0]       kind_i,
  input  logic [madr_pkg::CHAN_W-1:0]       chan_i,
  input  logic [madr_pkg::DELAY_W-1:0]      delay_i,
  input  logic signed [madr_pkg::SMP_W-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [madr_pkg::SMP_W-1:0] sample_out_o
);

  localparam int LIVE    = (CHANNELS < 2) ? CHANNELS : 2;
  localparam int MEM_N   = LIVE * DEPTH;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int AW      = $clog2(MEM_N);
  localparam int IW      = ((PTR_W > madr_pkg::DELAY_W) ? PTR_W : madr_pkg::DELAY_W) + 1;
  localparam int SUM_W   = ((PTR_W > madr_pkg::SLACK_W) ? PTR_W : madr_pkg::SLACK_W) + 1;
  localparam int SMP_W   = madr_pkg::SMP_W;
  localparam int DELAY_W = madr_pkg::DELAY_W;

  logic [madr_pkg::KIND_W-1:0] kind_q;
  logic                        chan_q;
  logic [DELAY_W-1:0]          delay_q;
  logic [SMP_W-1:0]            smp_q;
  logic [madr_pkg::SLACK_W-1:0] slack_q;
  logic [PTR_W-1:0]            ptr_q [LIVE];
  logic [AW-1:0]               clr_cnt_q;
  logic [SMP_W-1:0]            mem_q [MEM_N];
  logic [SMP_W-1:0]            rdata_q;
  logic                        out_valid_q;
  logic [SMP_W-1:0]            sample_out_q;

  logic                 hi_chan;
  logic                 present;
  logic [PTR_W-1:0]     sel_ptr;
  logic [DELAY_W-1:0]   red;
  logic [IW-1:0]        tap_dist;
  logic [IW-1:0]        tap_w;
  logic [PTR_W-1:0]     slot;
  logic [AW-1:0]        addr;
  logic [PTR_W-1:0]     ptr_inc;
  logic [PTR_W-1:0]     ptr_new;
  logic [SMP_W:0]       acc_sum;
  logic [SMP_W-1:0]     acc_sat;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [SMP_W-1:0]     mem_wdata;

  assign hi_chan = chan_q && (LIVE > 1);
  assign present = !chan_q || (LIVE > 1);
  assign sel_ptr = hi_chan ? ptr_q[LIVE-1] : ptr_q[0];

  // delay mod depth, restoring reduction
  always_comb begin
    red = delay_q;
    for (int k = DELAY_W - 1; k >= 0; k--) begin
      if (32'(red) >= (DEPTH << k)) begin
        red = red - DELAY_W'(DEPTH << k);
      end
    end
  end

  assign tap_dist = IW'(red);
  assign tap_w    = (IW'(sel_ptr) >= tap_dist) ? (IW'(sel_ptr) - tap_dist)
                                               : (IW'(sel_ptr) + IW'(DEPTH) - tap_dist);
  assign slot  = (kind_q == madr_pkg::KIND_WRITE) ? sel_ptr : PTR_W'(tap_w);
  assign addr  = AW'(slot) + (hi_chan ? AW'(DEPTH) : AW'(0));

  assign ptr_inc = (sel_ptr == PTR_W'(DEPTH - 1)) ? '0 : sel_ptr + PTR_W'(1);
  assign ptr_new = (hi_chan && ((SUM_W'(ptr_inc) + SUM_W'(slack_q)) < SUM_W'(ptr_q[0])))
                   ? ptr_q[0] : ptr_inc;

  assign acc_sum = {rdata_q[SMP_W-1], rdata_q} + {smp_q[SMP_W-1], smp_q};
  assign acc_sat = (acc_sum[SMP_W] != acc_sum[SMP_W-1])
                   ? (acc_sum[SMP_W] ? madr_pkg::SMP_MIN : madr_pkg::SMP_MAX)
                   : acc_sum[SMP_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = smp_q;
    if (cmd_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (cmd_i.mem_wr) begin
      mem_we    = present;
    end else if (cmd_i.acc_wb) begin
      mem_we    = present;
      mem_wdata = acc_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      kind_q  <= kind_i;
      chan_q  <= chan_i;
      delay_q <= delay_i;
      smp_q   <= sample_in_i;
    end
    if (cmd_i.out_load) begin
      sample_out_q <= present ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slack_q     <= madr_pkg::SLACK_RESET;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LIVE; i++) begin
        ptr_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
        for (int i = 0; i < LIVE; i++) begin
          ptr_q[i] <= '0;
        end
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.mem_wr && present) begin
        if (hi_chan) begin
          ptr_q[LIVE-1] <= ptr_new;
        end else begin
          ptr_q[0] <= ptr_new;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.clr_last = (clr_cnt_q == AW'(MEM_N - 1));
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  a_clr_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !(cmd_i.mem_wr || cmd_i.acc_wb || cmd_i.mem_rd))
    else $error("store access during clearing sweep");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_ptr <= PTR_W'(DEPTH - 1))
    else $error("write pointer beyond depth");

  a_clr_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_start |=> (ptr_q[0] == '0 && clr_cnt_q == '0))
    else $error("clear did not reset pointers");

endmodule

// ----- rtl/multichannel_audio_delay_ring.sv -----
// Write beat: the sample is written in the execute state, then the next beat can be taken.
// Read beat: stored sample registered in execute, loaded to the output register in response,
// which waits while the output is stalled; read/accumulate hold the input until back in idle.
// Accumulate is a read-modify-write on the single sample RAM port pair. Clear beat: sweeps all
// min(CHANNELS,2)*DEPTH entries, one entry swept per cycle; after reset the same sweep runs with input stalled.
// rst_ni is asynchronous: pointers zeroed, slack back to 128, output beat dropped.
module multichannel_audio_delay_ring #(
  parameter int DEPTH    = madr_pkg::DEPTH_DEFAULT,
  parameter int CHANNELS = madr_pkg::CHANNELS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [madr_pkg::SLACK_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [madr_pkg::KIND_W-1:0]       kind_i,
  input  logic [madr_pkg::CHAN_W-1:0]       chan_i,
  input  logic [madr_pkg::DELAY_W-1:0]      delay_i,
  input  logic signed [madr_pkg::SMP_W-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [madr_pkg::SMP_W-1:0] sample_out_o
);

  madr_pkg::cmd_t cmd;
  madr_pkg::sts_t sts;

  madr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  madr_dp #(
    .DEPTH    (DEPTH),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .chan_i       (chan_i),
    .delay_i      (delay_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

endmodule
